@@ rtl/flg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flg_pkg
// Shared types, codes and constants of the GPU frequency level governor.
// ----------------------------------------------------------------------------
package flg_pkg;

    // Default parameter values
    localparam int LEVEL_BITS_DEF = 4;
    localparam int BIN_WIDTH_DEF  = 32;

    // Field widths fixed by the register and item layout
    localparam int US_W    = 20;
    localparam int REQ_W   = 2;
    localparam int MODE_W  = 2;
    localparam int LCNT_W  = 5;
    localparam int DLVL_W  = 4;
    localparam int LAZY_W  = 8;
    localparam int VOTE_W  = 5;
    localparam int NSW_W   = 8;
    localparam int SKIP_W  = 10;
    localparam int CIDX_W  = 3;

    // Top-level muting thresholds
    localparam logic [NSW_W-1:0]  NSW_MUTE_LIMIT     = NSW_W'(200);
    localparam logic [NSW_W-1:0]  NSW_RELEASE_STEP   = NSW_W'(40);
    localparam logic [SKIP_W-1:0] SKIP_RELEASE_LIMIT = SKIP_W'(500);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SLEEP  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WAKE   = 2'd2;

    // Governor mode codes
    localparam logic [MODE_W-1:0] MODE_PERFORMANCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONDEMAND    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIMPLE      = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_GOVERNOR_MODE   = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LEVEL_COUNT     = 3'd1;
    localparam logic [CIDX_W-1:0] REG_DEFAULT_LEVEL   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_LAZINESS_RELOAD = 3'd3;
    localparam logic [CIDX_W-1:0] REG_RAMP_THRESHOLD  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_FLOOR           = 3'd5;
    localparam logic [CIDX_W-1:0] REG_CEILING         = 3'd6;

    // Configuration register set
    typedef struct packed {
        logic [MODE_W-1:0] governor_mode;
        logic [LCNT_W-1:0] level_count;
        logic [DLVL_W-1:0] default_level;
        logic [LAZY_W-1:0] laziness_reload;
        logic [US_W-1:0]   ramp_threshold_us;
        logic [US_W-1:0]   floor_us;
        logic [US_W-1:0]   ceiling_us;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        governor_mode:     MODE_ONDEMAND,
        level_count:       LCNT_W'(4),
        default_level:     DLVL_W'(1),
        laziness_reload:   LAZY_W'(5),
        ramp_threshold_us: US_W'(6000),
        floor_us:          US_W'(5000),
        ceiling_us:        US_W'(50000)
    };

    // Decision counters
    typedef struct packed {
        logic [NSW_W-1:0]  no_switch_count;
        logic [SKIP_W-1:0] skip_count;
        logic [LAZY_W-1:0] laziness_left;
    } cnt_t;

endpackage

@@ rtl/flg_decide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flg_decide
// Decision logic for one request: bin update, top-level muting, level vote,
// clamping, and the next values of the bins and counters.
// ----------------------------------------------------------------------------
module flg_decide #(
    parameter int LEVEL_BITS = flg_pkg::LEVEL_BITS_DEF,
    parameter int BIN_WIDTH  = flg_pkg::BIN_WIDTH_DEF
) (
    input  flg_pkg::cfg_t                      cfg,
    input  flg_pkg::cnt_t                      cnt,
    input  logic [BIN_WIDTH-1:0]               total_bin,
    input  logic [BIN_WIDTH-1:0]               busy_bin,
    input  logic [flg_pkg::REQ_W-1:0]          req_type,
    input  logic [flg_pkg::US_W-1:0]           elapsed_us,
    input  logic [flg_pkg::US_W-1:0]           busy_us,
    input  logic [LEVEL_BITS-1:0]              current_level,
    input  logic                               device_napping,
    input  logic signed [flg_pkg::VOTE_W-1:0]  external_vote,
    output flg_pkg::cnt_t                      cnt_next,
    output logic [BIN_WIDTH-1:0]               total_next,
    output logic [BIN_WIDTH-1:0]               busy_next,
    output logic                               level_change,
    output logic [LEVEL_BITS-1:0]              new_level,
    output logic                               engine_reset
);
    import flg_pkg::*;

    localparam int LEVELS_MAX = 1 << LEVEL_BITS;
    localparam int SW         = LEVEL_BITS + 7;

    logic                   active;
    logic [BIN_WIDTH:0]     total_sum;
    logic [BIN_WIDTH:0]     busy_sum;
    logic [BIN_WIDTH-1:0]   total_sat;
    logic [BIN_WIDTH-1:0]   busy_sat;
    logic [BIN_WIDTH-1:0]   idle;
    logic [7:0]             lc8;
    logic [7:0]             top_w;
    logic [7:0]             cur8;
    logic [LEVEL_BITS-1:0]  top;
    logic [SKIP_W-1:0]      skip_inc;
    logic signed [5:0]      delta;
    logic signed [SW-1:0]   lv_sum;

    // Highest valid level index from the level count
    always_comb begin
        lc8 = 8'(cfg.level_count);
        if (lc8 == 8'd0) begin
            top_w = 8'd0;
        end else if (lc8 > 8'(LEVELS_MAX)) begin
            top_w = 8'(LEVELS_MAX - 1);
        end else begin
            top_w = lc8 - 8'd1;
        end
        top = top_w[LEVEL_BITS-1:0];
    end

    // Saturating bin sums and idle time
    assign total_sum = (BIN_WIDTH+1)'(total_bin) + (BIN_WIDTH+1)'(elapsed_us);
    assign busy_sum  = (BIN_WIDTH+1)'(busy_bin) + (BIN_WIDTH+1)'(busy_us);
    assign total_sat = total_sum[BIN_WIDTH] ? '1 : total_sum[BIN_WIDTH-1:0];
    assign busy_sat  = busy_sum[BIN_WIDTH] ? '1 : busy_sum[BIN_WIDTH-1:0];
    assign idle      = (total_sat > busy_sat) ? (total_sat - busy_sat) : '0;

    assign active   = (cfg.governor_mode == MODE_ONDEMAND) ||
                      (cfg.governor_mode == MODE_SIMPLE);
    assign cur8     = 8'(current_level);
    assign skip_inc = cnt.skip_count + SKIP_W'(1);

    // Request handling
    always_comb begin
        cnt_next     = cnt;
        total_next   = total_bin;
        busy_next    = busy_bin;
        level_change = 1'b0;
        new_level    = '0;
        engine_reset = 1'b0;
        delta        = '0;
        lv_sum       = '0;

        priority if (req_type == REQ_SLEEP) begin
            // drop gathered time and the no-switch history
            cnt_next.no_switch_count = '0;
            total_next   = '0;
            busy_next    = '0;
            engine_reset = 1'b1;
        end else if (req_type == REQ_WAKE) begin
            // restore the default level, clamped
            if (!device_napping && active) begin
                level_change = 1'b1;
                if (8'(cfg.default_level) > top_w) begin
                    new_level = top;
                end else begin
                    new_level = LEVEL_BITS'(cfg.default_level);
                end
            end
        end else if (req_type == REQ_SAMPLE && active) begin
            total_next = total_sat;
            busy_next  = busy_sat;
            if (elapsed_us != '0 && total_sat >= BIN_WIDTH'(cfg.floor_us)) begin
                if (current_level == '0 && cnt.no_switch_count > NSW_MUTE_LIMIT) begin
                    // muted at the fastest level: keep the bins
                    cnt_next.skip_count = skip_inc;
                    if (skip_inc > SKIP_RELEASE_LIMIT) begin
                        cnt_next.no_switch_count =
                            cnt.no_switch_count - NSW_RELEASE_STEP;
                        cnt_next.skip_count = '0;
                    end
                end else begin
                    if (current_level == '0) begin
                        if (cnt.no_switch_count != '1) begin
                            cnt_next.no_switch_count = cnt.no_switch_count + NSW_W'(1);
                        end
                    end else begin
                        cnt_next.no_switch_count = '0;
                    end

                    // pick the level step
                    priority if (busy_sat > BIN_WIDTH'(cfg.ceiling_us)) begin
                        delta = -6'sd1;
                    end else if (cfg.governor_mode == MODE_SIMPLE) begin
                        if (idle < BIN_WIDTH'(cfg.ramp_threshold_us)) begin
                            if (cur8 > 8'd0 && cur8 <= top_w) begin
                                delta = -6'sd1;
                            end
                        end else if (cur8 < top_w) begin
                            if (cnt.laziness_left != '0) begin
                                cnt_next.laziness_left = cnt.laziness_left - LAZY_W'(1);
                            end else begin
                                cnt_next.laziness_left = cfg.laziness_reload;
                                delta = 6'sd1;
                            end
                        end
                    end else begin
                        delta = 6'(external_vote);
                    end

                    total_next = '0;
                    busy_next  = '0;
                    if (delta != '0) begin
                        level_change = 1'b1;
                        lv_sum = signed'(SW'(current_level)) + SW'(delta);
                        if (lv_sum < 0) begin
                            new_level = '0;
                        end else if (lv_sum > signed'(SW'(top_w))) begin
                            new_level = top;
                        end else begin
                            new_level = lv_sum[LEVEL_BITS-1:0];
                        end
                    end
                end
            end
        end else begin
            // unknown request, or a sample outside ondemand and simple modes: no effect
        end
    end

endmodule

@@ rtl/gpu_frequency_level_governor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_frequency_level_governor_top
// Utilization driven power-level governor: takes idle-sample, sleep and wake
// requests and returns one level decision per request.
// ----------------------------------------------------------------------------
//  Channel   Prefix  Direction  Carries
//  request   s_      in         req_type, elapsed/busy time, level, nap, vote
//  result    m_      out        level_change, new_level, engine_reset
//  config    cfg_    in         register index and write data
//
//  One request per cycle while m_ready is high; the input register takes the
//  request at the accepting edge, and the result is presented once the
//  decision lands in the result register.
//  Reset loads the register defaults and clears the bins and counters.
//  With m_ready low the result holds, the input register takes one more
//  request, then s_ready drops. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module gpu_frequency_level_governor_top #(
    parameter int LEVEL_BITS = flg_pkg::LEVEL_BITS_DEF,
    parameter int BIN_WIDTH  = flg_pkg::BIN_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [flg_pkg::REQ_W-1:0]          s_req_type,
    input  logic [flg_pkg::US_W-1:0]           s_elapsed_us,
    input  logic [flg_pkg::US_W-1:0]           s_busy_us,
    input  logic [LEVEL_BITS-1:0]              s_current_level,
    input  logic                               s_device_napping,
    input  logic signed [flg_pkg::VOTE_W-1:0]  s_external_vote,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_level_change,
    output logic [LEVEL_BITS-1:0]              m_new_level,
    output logic                               m_engine_reset,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [flg_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [flg_pkg::US_W-1:0]           cfg_data
);
    import flg_pkg::*;

    cfg_t                    cfg_reg;
    cnt_t                    cnt_reg;
    cnt_t                    cnt_next;
    logic [BIN_WIDTH-1:0]    total_bin_reg;
    logic [BIN_WIDTH-1:0]    busy_bin_reg;
    logic [BIN_WIDTH-1:0]    total_next;
    logic [BIN_WIDTH-1:0]    busy_next;

    logic                    in_valid_reg;
    logic                    in_valid_next;
    logic [REQ_W-1:0]        in_req_reg;
    logic [US_W-1:0]         in_elapsed_reg;
    logic [US_W-1:0]         in_busy_reg;
    logic [LEVEL_BITS-1:0]   in_level_reg;
    logic                    in_nap_reg;
    logic signed [VOTE_W-1:0] in_vote_reg;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    logic                    m_change_reg;
    logic [LEVEL_BITS-1:0]   m_level_reg;
    logic                    m_ereset_reg;

    logic                    dec_change;
    logic [LEVEL_BITS-1:0]   dec_level;
    logic                    dec_ereset;
    logic                    advance;
    logic                    s_accept;

    // Handshake control
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // Decision logic on the registered request
    flg_decide #(
        .LEVEL_BITS (LEVEL_BITS),
        .BIN_WIDTH  (BIN_WIDTH)
    ) u_decide (
        .cfg            (cfg_reg),
        .cnt            (cnt_reg),
        .total_bin      (total_bin_reg),
        .busy_bin       (busy_bin_reg),
        .req_type       (in_req_reg),
        .elapsed_us     (in_elapsed_reg),
        .busy_us        (in_busy_reg),
        .current_level  (in_level_reg),
        .device_napping (in_nap_reg),
        .external_vote  (in_vote_reg),
        .cnt_next       (cnt_next),
        .total_next     (total_next),
        .busy_next      (busy_next),
        .level_change   (dec_change),
        .new_level      (dec_level),
        .engine_reset   (dec_ereset)
    );

    // Hold control state, configuration, bins and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            cfg_reg       <= CFG_RESET;
            cnt_reg       <= '0;
            total_bin_reg <= '0;
            busy_bin_reg  <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                cnt_reg       <= cnt_next;
                total_bin_reg <= total_next;
                busy_bin_reg  <= busy_next;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_GOVERNOR_MODE:   cfg_reg.governor_mode     <= cfg_data[MODE_W-1:0];
                    REG_LEVEL_COUNT:     cfg_reg.level_count       <= cfg_data[LCNT_W-1:0];
                    REG_DEFAULT_LEVEL:   cfg_reg.default_level     <= cfg_data[DLVL_W-1:0];
                    REG_LAZINESS_RELOAD: cfg_reg.laziness_reload   <= cfg_data[LAZY_W-1:0];
                    REG_RAMP_THRESHOLD:  cfg_reg.ramp_threshold_us <= cfg_data;
                    REG_FLOOR:           cfg_reg.floor_us          <= cfg_data;
                    REG_CEILING:         cfg_reg.ceiling_us        <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Capture the request transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg     <= s_req_type;
            in_elapsed_reg <= s_elapsed_us;
            in_busy_reg    <= s_busy_us;
            in_level_reg   <= s_current_level;
            in_nap_reg     <= s_device_napping;
            in_vote_reg    <= s_external_vote;
        end
    end

    // Load the result transaction
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_change_reg <= dec_change;
            m_level_reg  <= dec_level;
            m_ereset_reg <= dec_ereset;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_level_change = m_change_reg;
    assign m_new_level    = m_level_reg;
    assign m_engine_reset = m_ereset_reg;

    // Checks
    a_sleep_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_ereset_reg && m_change_reg))
        else $error("sleep result also requests a level change");

    a_level_zero_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_change_reg) |-> (m_level_reg == '0))
        else $error("new level nonzero without a level change");

    a_level_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_change_reg) |->
            ((8'(m_level_reg) < 8'(cfg_reg.level_count)) || (m_level_reg == '0)))
        else $error("requested level beyond level count");

    a_sleep_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg == REQ_SLEEP) |=>
            (total_bin_reg == '0 && busy_bin_reg == '0 &&
             cnt_reg.no_switch_count == '0))
        else $error("sleep did not clear bins");

    a_skip_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg.skip_count <= SKIP_RELEASE_LIMIT)
        else $error("skip counter past its limit");

endmodule
